@@ sv/anagram_window_matcher_core_macros.svh @@
// Assertion shorthands for the anagram window matcher.
`ifndef ANAGRAM_WINDOW_MATCHER_CORE_MACROS_SVH
`define ANAGRAM_WINDOW_MATCHER_CORE_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define AWM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while in reset.
`define AWM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked through reset.
`define AWM_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/awm_pkg.sv @@
package awm_pkg;

  localparam int FUNC_W   = 2;
  localparam int LETTER_W = 5;
  localparam int START_W  = 16;

  localparam int DEF_MAX_PATTERN = 256;
  localparam int DEF_ALPHABET    = 26;
  localparam int DEF_MAX_TEXT    = 65536;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR   = 2'd0,
    FN_PATTERN = 2'd1,
    FN_TEXT    = 2'd2
  } func_t;

  // Shared update command broadcast to every letter lane.
  typedef struct packed {
    logic                clr;
    logic                pat_add;
    logic                win_add;
    logic                win_sub;
    logic [LETTER_W-1:0] code;
    logic [LETTER_W-1:0] old;
  } lane_ctl_t;

  // Recent-letter ring command.
  typedef struct packed {
    logic                clr;
    logic                adv;
    logic [LETTER_W-1:0] letter;
  } ring_ctl_t;

endpackage

@@ sv/awm_if.sv @@
interface awm_in_if;
  logic                        valid;
  logic                        ready;
  logic [awm_pkg::FUNC_W-1:0]   func;
  logic [awm_pkg::LETTER_W-1:0] letter;

  modport source (output valid, output func, output letter, input ready);
  modport sink   (input valid, input func, input letter, output ready);
endinterface

interface awm_out_if;
  logic                        valid;
  logic                        ready;
  logic [awm_pkg::START_W-1:0]  start_index;

  modport source (output valid, output start_index, input ready);
  modport sink   (input valid, input start_index, output ready);
endinterface

@@ sv/awm_lane.sv @@
module awm_lane #(
  parameter int LANE  = 0,
  parameter int CNT_W = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  awm_pkg::lane_ctl_t  ctl,
  output logic                diff_nxt
);

  logic [CNT_W-1:0] pat_r, pat_nxt;
  logic [CNT_W-1:0] win_r, win_nxt;
  logic             hit_new, hit_old;

  always_comb begin
    hit_new = (32'(ctl.code) == LANE);
    hit_old = (32'(ctl.old) == LANE);
    pat_nxt = pat_r;
    win_nxt = win_r;
    if (ctl.clr) begin
      pat_nxt = '0;
      win_nxt = '0;
    end else begin
      if (ctl.pat_add && hit_new) begin
        pat_nxt = pat_r + CNT_W'(1);
      end
      case ({ctl.win_add && hit_new, ctl.win_sub && hit_old})
        2'b10:   win_nxt = win_r + CNT_W'(1);
        2'b01:   win_nxt = win_r - CNT_W'(1);
        default: win_nxt = win_r;
      endcase
    end
    diff_nxt = (pat_nxt != win_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
      win_r <= '0;
    end else begin
      pat_r <= pat_nxt;
      win_r <= win_nxt;
    end
  end

endmodule

@@ sv/awm_ring.sv @@
module awm_ring #(
  parameter int MAX_PATTERN = awm_pkg::DEF_MAX_PATTERN,
  parameter int PC_W        = 9,
  parameter int SLOT_W      = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  awm_pkg::ring_ctl_t           ctl,
  input  logic [PC_W-1:0]              pattern_count,
  output logic [awm_pkg::LETTER_W-1:0] old_letter
);

  logic [SLOT_W-1:0]            slot_r, slot_nxt;
  logic [awm_pkg::LETTER_W-1:0] mem [MAX_PATTERN];
  logic [awm_pkg::LETTER_W-1:0] rd_r;

  always_comb begin
    slot_nxt = slot_r;
    if (ctl.clr) begin
      slot_nxt = '0;
    end else if (ctl.adv) begin
      if (PC_W'(slot_r) + PC_W'(1) == pattern_count) begin
        slot_nxt = '0;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  // Prefetch the slot the next text beat will use; bypass when the ring is one deep.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      mem[slot_r] <= ctl.letter;
    end
    if (ctl.adv && (slot_nxt == slot_r)) begin
      rd_r <= ctl.letter;
    end else begin
      rd_r <= mem[slot_nxt];
    end
  end

  assign old_letter = rd_r;

endmodule

@@ sv/anagram_window_matcher_core.sv @@
// Sliding-window anagram search. Send func=clear, then the pattern letters
// (func=pattern), then the text letters (func=text); each text letter that
// closes a window whose letter counts equal the pattern's returns one beat
// carrying the window's start index. The block takes one beat per clock:
// a beat is registered, updated through one pass of per-letter count lanes
// and a ring read that is prefetched for the next text beat, and the result
// lands in the output register once the held beat is processed. Input
// stalls only while a beat is held and the output register is full and not
// taken. The recent-letter ring needs no clearing after reset.
module anagram_window_matcher_core #(
  parameter int MAX_PATTERN = awm_pkg::DEF_MAX_PATTERN,
  parameter int ALPHABET    = awm_pkg::DEF_ALPHABET,
  parameter int MAX_TEXT    = awm_pkg::DEF_MAX_TEXT
) (
  input  logic            clk,
  input  logic            rst_n,
  awm_in_if.sink          in_ch,
  awm_out_if.source       out_ch
);

  localparam int PC_W   = $clog2(MAX_PATTERN + 1);
  localparam int SLOT_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int TC_W   = $clog2(MAX_TEXT + 1);

  logic                          in_v_r;
  logic [awm_pkg::FUNC_W-1:0]    func_r;
  logic [awm_pkg::LETTER_W-1:0]  letter_r;
  logic [PC_W-1:0]               pc_r, pc_nxt;
  logic [TC_W-1:0]               tc_r, tc_nxt;
  logic                          out_v_r;
  logic [awm_pkg::START_W-1:0]   out_idx_r;

  logic                          proc_go, proc, in_rdy;
  logic                          is_clr, is_pat, is_text, win_step;
  logic                          letter_ok, reach, full, emit;
  logic [31:0]                   pos32, pc32, start32;
  logic [awm_pkg::LETTER_W-1:0]  old_letter;
  logic [ALPHABET-1:0]           diff_nxt;
  awm_pkg::lane_ctl_t            lane_ctl;
  awm_pkg::ring_ctl_t            ring_ctl;

  assign proc_go = !out_v_r || out_ch.ready;
  assign proc    = in_v_r && proc_go;
  assign in_rdy  = !in_v_r || proc_go;

  always_comb begin
    is_clr    = 1'b0;
    is_pat    = 1'b0;
    is_text   = 1'b0;
    letter_ok = (32'(letter_r) < ALPHABET);
    case (awm_pkg::func_t'(func_r))
      awm_pkg::FN_CLEAR:   is_clr  = proc;
      awm_pkg::FN_PATTERN: is_pat  = proc && letter_ok && (tc_r == '0)
                                     && (pc_r < PC_W'(MAX_PATTERN));
      awm_pkg::FN_TEXT:    is_text = proc && letter_ok && (tc_r < TC_W'(MAX_TEXT));
      default: begin
        is_clr  = 1'b0;
        is_pat  = 1'b0;
        is_text = 1'b0;
      end
    endcase
    win_step = is_text && (pc_r != '0);
    pos32    = 32'(tc_r);
    pc32     = 32'(pc_r);
    full     = (pos32 >= pc32);
    reach    = (pos32 + 32'd1 >= pc32);
    start32  = pos32 + 32'd1 - pc32;
    emit     = win_step && reach && !(|diff_nxt);

    lane_ctl.clr     = is_clr;
    lane_ctl.pat_add = is_pat;
    lane_ctl.win_add = win_step;
    lane_ctl.win_sub = win_step && full;
    lane_ctl.code    = letter_r;
    lane_ctl.old     = old_letter;

    ring_ctl.clr     = is_clr;
    ring_ctl.adv     = win_step;
    ring_ctl.letter  = letter_r;

    pc_nxt = pc_r;
    tc_nxt = tc_r;
    if (is_clr) begin
      pc_nxt = '0;
      tc_nxt = '0;
    end else begin
      if (is_pat) begin
        pc_nxt = pc_r + PC_W'(1);
      end
      if (is_text) begin
        tc_nxt = tc_r + TC_W'(1);
      end
    end
  end

  for (genvar i = 0; i < ALPHABET; i++) begin : g_lane
    awm_lane #(
      .LANE  (i),
      .CNT_W (PC_W)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lane_ctl),
      .diff_nxt (diff_nxt[i])
    );
  end

  awm_ring #(
    .MAX_PATTERN (MAX_PATTERN),
    .PC_W        (PC_W),
    .SLOT_W      (SLOT_W)
  ) u_ring (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ring_ctl),
    .pattern_count (pc_r),
    .old_letter    (old_letter)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      pc_r    <= '0;
      tc_r    <= '0;
    end else begin
      pc_r <= pc_nxt;
      tc_r <= tc_nxt;
      if (in_rdy) begin
        in_v_r <= in_ch.valid;
      end
      if (proc_go) begin
        out_v_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      func_r   <= in_ch.func;
      letter_r <= in_ch.letter;
    end
    if (proc_go && emit) begin
      out_idx_r <= start32[awm_pkg::START_W-1:0];
    end
  end

  assign in_ch.ready        = in_rdy;
  assign out_ch.valid       = out_v_r;
  assign out_ch.start_index = out_idx_r;

endmodule

@@ sv/awm_checker.sv @@
`include "anagram_window_matcher_core_macros.svh"

module awm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [awm_pkg::START_W-1:0] out_start_index
);

  `AWM_ASSERT_NXT_ALWAYS(a_rst_out_idle, clk, !rst_n, !out_valid)
  `AWM_ASSERT_IMP(a_stall_only_on_full_out, clk, rst_n, !in_ready, out_valid && !out_ready)
  `AWM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                  out_valid && $stable(out_start_index))
  `AWM_ASSERT_NXT(a_no_out_from_idle, clk, rst_n,
                  (!in_valid && in_ready) ##1 !out_valid, !out_valid)

endmodule

bind anagram_window_matcher_core awm_checker u_awm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_start_index (out_ch.start_index)
);

@@ tb/tb.sv @@
module tb;

  localparam logic [awm_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int ALPHA   = awm_pkg::DEF_ALPHABET;
  localparam int MAX_PAT = awm_pkg::DEF_MAX_PATTERN;
  localparam int MAX_TXT = awm_pkg::DEF_MAX_TEXT;
  localparam int LIMIT_CYCLES = 500_000;

  typedef struct packed {
    logic [awm_pkg::FUNC_W-1:0]   func;
    logic [awm_pkg::LETTER_W-1:0] letter;
    logic                         typed;
    logic                         hit;
    logic [awm_pkg::START_W-1:0]  idx;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  awm_in_if  in_ch();
  awm_out_if out_ch();

  anagram_window_matcher_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [8:0]                   pat_hist [ALPHA];
  logic [8:0]                   win_hist [ALPHA];
  logic [awm_pkg::LETTER_W-1:0] ring [MAX_PAT];
  logic [8:0]                   pat_len;
  logic [16:0]                  txt_len;
  logic [4:0]                   n_diff;

  logic [awm_pkg::START_W-1:0] match_q [$];
  int errors      = 0;
  int beats_sent  = 0;
  int live_beats  = 0;
  int matches_seen = 0;
  int send_idle   = 0;
  int recv_stall  = 0;

  beat_t dir_rows [24] = '{
    '{awm_pkg::FN_TEXT,    5'd0,  1'b1, 1'b0, 16'd0},
    '{awm_pkg::FN_PATTERN, 5'd0,  1'b1, 1'b0, 16'd0},
    '{awm_pkg::FN_CLEAR,   5'd31, 1'b1, 1'b0, 16'd0},
    '{FN_UNUSED,           5'd31, 1'b1, 1'b0, 16'd0},
    '{awm_pkg::FN_PATTERN, 5'd31, 1'b1, 1'b0, 16'd0},
    '{awm_pkg::FN_PATTERN, 5'd0,  1'b1, 1'b0, 16'd0},
    '{awm_pkg::FN_PATTERN, 5'd25, 1'b1, 1'b0, 16'd0},
    '{awm_pkg::FN_PATTERN, 5'd0,  1'b1, 1'b0, 16'd0},
    '{awm_pkg::FN_TEXT,    5'd26, 1'b1, 1'b0, 16'd0},
    '{awm_pkg::FN_TEXT,    5'd25, 1'b1, 1'b0, 16'd0},
    '{awm_pkg::FN_TEXT,    5'd0,  1'b1, 1'b0, 16'd0},
    '{awm_pkg::FN_TEXT,    5'd0,  1'b1, 1'b1, 16'd0},
    '{awm_pkg::FN_TEXT,    5'd25, 1'b1, 1'b1, 16'd1},
    '{awm_pkg::FN_TEXT,    5'd1,  1'b0, 1'b0, 16'd0},
    '{awm_pkg::FN_TEXT,    5'd0,  1'b0, 1'b0, 16'd0},
    '{awm_pkg::FN_PATTERN, 5'd25, 1'b1, 1'b0, 16'd0},
    '{awm_pkg::FN_TEXT,    5'd0,  1'b0, 1'b0, 16'd0},
    '{awm_pkg::FN_TEXT,    5'd25, 1'b0, 1'b0, 16'd0},
    '{awm_pkg::FN_CLEAR,   5'd0,  1'b1, 1'b0, 16'd0},
    '{awm_pkg::FN_PATTERN, 5'd25, 1'b1, 1'b0, 16'd0},
    '{awm_pkg::FN_TEXT,    5'd25, 1'b1, 1'b1, 16'd0},
    '{awm_pkg::FN_TEXT,    5'd31, 1'b1, 1'b0, 16'd0},
    '{awm_pkg::FN_TEXT,    5'd25, 1'b1, 1'b1, 16'd1},
    '{awm_pkg::FN_CLEAR,   5'd0,  1'b1, 1'b0, 16'd0}
  };

  function automatic beat_t mk(input logic [awm_pkg::FUNC_W-1:0] f, input int l);
    beat_t b;
    b = '0;
    b.func   = f;
    b.letter = awm_pkg::LETTER_W'(l);
    return b;
  endfunction

  task automatic clear_search();
    for (int i = 0; i < ALPHA; i++) begin
      pat_hist[i] = '0;
      win_hist[i] = '0;
    end
    pat_len = '0;
    txt_len = '0;
    n_diff  = '0;
  endtask

  task automatic bump(input bit win, input int code, input bit up);
    bit was_diff, now_diff;
    was_diff = pat_hist[code] != win_hist[code];
    if (win) begin
      win_hist[code] = up ? win_hist[code] + 9'd1 : win_hist[code] - 9'd1;
    end else begin
      pat_hist[code] = pat_hist[code] + 9'd1;
    end
    now_diff = pat_hist[code] != win_hist[code];
    if (was_diff && !now_diff) begin
      n_diff = n_diff - 5'd1;
    end else if (!was_diff && now_diff) begin
      n_diff = n_diff + 5'd1;
    end
  endtask

  task automatic predict_match(input logic [awm_pkg::FUNC_W-1:0] f,
                               input logic [awm_pkg::LETTER_W-1:0] l,
                               output bit hit, output logic [awm_pkg::START_W-1:0] idx);
    int pos, slot;
    hit = 1'b0;
    idx = '0;
    if (f == awm_pkg::FN_CLEAR) begin
      clear_search();
    end else if (f != FN_UNUSED && int'(l) < ALPHA) begin
      if (f == awm_pkg::FN_PATTERN) begin
        if (txt_len == 0 && int'(pat_len) < MAX_PAT) begin
          bump(1'b0, int'(l), 1'b1);
          pat_len = pat_len + 9'd1;
        end
      end else if (int'(txt_len) < MAX_TXT) begin
        pos = int'(txt_len);
        txt_len = txt_len + 17'd1;
        if (pat_len != 0) begin
          slot = pos % int'(pat_len);
          if (pos >= int'(pat_len)) bump(1'b1, int'(ring[slot]), 1'b0);
          ring[slot] = l;
          bump(1'b1, int'(l), 1'b1);
          if (pos + 1 >= int'(pat_len) && n_diff == 0) begin
            hit = 1'b1;
            idx = awm_pkg::START_W'(pos + 1 - int'(pat_len));
          end
        end
      end
    end
  endtask

  task automatic send_beat(input beat_t b);
    bit hit;
    logic [awm_pkg::START_W-1:0] idx;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.func   <= b.func;
    in_ch.letter <= b.letter;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_match(b.func, b.letter, hit, idx);
    if (b.typed) begin
      hit = b.hit;
      idx = b.idx;
    end
    if (hit) match_q = {match_q, idx};
    beats_sent++;
    if (!(b.func == FN_UNUSED || int'(b.letter) >= ALPHA)) live_beats++;
  endtask

  // one search: clear, short pattern over a narrow letter range, text mostly from it
  task automatic random_search();
    int plen, tlen, base, span, roll;
    send_beat(mk(awm_pkg::FN_CLEAR, $urandom_range(31)));
    plen = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 6);
    span = $urandom_range(1, 4);
    base = $urandom_range(0, ALPHA - span);
    for (int p = 0; p < plen; p++) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        send_beat(mk(FN_UNUSED, $urandom_range(31)));
      end else if (roll < 10) begin
        send_beat(mk(awm_pkg::FN_PATTERN, $urandom_range(ALPHA, 31)));
      end
      send_beat(mk(awm_pkg::FN_PATTERN, base + $urandom_range(0, span - 1)));
    end
    tlen = $urandom_range(4, 30);
    for (int t = 0; t < tlen; t++) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        send_beat(mk(FN_UNUSED, $urandom_range(31)));
      end else if (roll < 6) begin
        send_beat(mk(awm_pkg::FN_PATTERN, $urandom_range(31)));
      end else if (roll < 9) begin
        send_beat(mk(awm_pkg::FN_TEXT, $urandom_range(ALPHA, 31)));
      end else if (roll < 15) begin
        send_beat(mk(awm_pkg::FN_TEXT, $urandom_range(0, ALPHA - 1)));
      end else begin
        send_beat(mk(awm_pkg::FN_TEXT, base + $urandom_range(0, span - 1)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      matches_seen++;
      if (match_q.size() == 0) begin
        $display("%0t: start_index expected none, actual %0d", $time, out_ch.start_index);
        errors++;
      end else begin
        if (out_ch.start_index !== match_q[0]) begin
          $display("%0t: start_index expected %0d, actual %0d",
                   $time, match_q[0], out_ch.start_index);
          errors++;
        end
        void'(match_q.pop_front());
      end
    end
  end

  initial begin
    int target;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.func   = '0;
    in_ch.letter = '0;
    out_ch.ready = 1'b0;
    clear_search();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_beat(dir_rows[i]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 50; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 50; end
        default: begin send_idle = 12; recv_stall = 12; end
      endcase
      target = live_beats + 90;
      while (live_beats < target) random_search();
    end

    send_idle  = 0;
    recv_stall = 0;

    in_ch.valid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d input beats (%0d not ignored by field), compared %0d start indices.",
             beats_sent, live_beats, matches_seen);
    $display("Covered clear, unused selector, bad letter codes, late pattern letters and");
    $display("empty patterns, with sender idling and receiver stalls.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("Some tests failed");
    $finish;
  end

endmodule
